// File: design/assert_macros.svh
// assertion macros used by the top-level design file
// expects clk and rst_n in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/tbm_pkg.sv
// shared constants and types for the byte machine execute block
// no dependencies
package tbm_pkg;

    localparam int REG_COUNT   = 6;
    localparam int PORT_SELECT = 7;
    localparam int REG_AW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    localparam logic [7:0] REG_COUNT_B   = 8'(REG_COUNT);
    localparam logic [7:0] PORT_SELECT_B = 8'(PORT_SELECT);

    // opcode bit positions
    localparam int IMM_FIRST_BIT  = 7;
    localparam int IMM_SECOND_BIT = 6;
    localparam int COND_BIT       = 5;

    // alu operation codes
    localparam logic [4:0] OP_ADD = 5'd0;
    localparam logic [4:0] OP_SUB = 5'd1;
    localparam logic [4:0] OP_AND = 5'd2;
    localparam logic [4:0] OP_OR  = 5'd3;
    localparam logic [4:0] OP_NOT = 5'd4;
    localparam logic [4:0] OP_XOR = 5'd5;

    // conditional jump codes
    localparam logic [4:0] CMP_EQ = 5'd0;
    localparam logic [4:0] CMP_NE = 5'd1;
    localparam logic [4:0] CMP_LT = 5'd2;
    localparam logic [4:0] CMP_LE = 5'd3;
    localparam logic [4:0] CMP_GT = 5'd4;
    localparam logic [4:0] CMP_GE = 5'd5;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] first_sel;
        logic [7:0] second_sel;
        logic [7:0] target;
        logic [7:0] port_in_first;
        logic [7:0] port_in_second;
    } instr_t;

    typedef struct packed {
        logic [7:0]        next_index;
        logic              port_out_valid;
        logic [7:0]        port_out_value;
        logic              fault;
        logic              wr_en;
        logic [REG_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
    } exec_res_t;

endpackage

// File: design/tbm_regfile.sv
// register file: synchronous two-read one-write memory with registered read data
// depends on tbm_pkg
module tbm_regfile (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [tbm_pkg::REG_AW-1:0] rd_addr_a,
    input  logic [tbm_pkg::REG_AW-1:0] rd_addr_b,
    input  logic                      wr_en,
    input  logic [tbm_pkg::REG_AW-1:0] wr_addr,
    input  logic [7:0]                wr_data,
    output logic [7:0]                rd_data_a,
    output logic [7:0]                rd_data_b
);
    import tbm_pkg::*;

    logic [7:0]           mem [REG_COUNT];
    logic [REG_COUNT-1:0] written_reg;
    logic [7:0]           rd_data_a_reg;
    logic [7:0]           rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else if (wr_en)
        begin
            written_reg[wr_addr] <= 1'b1;
        end
    end

    // write-through so a read in the same cycle as a write sees the new byte
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && wr_addr == rd_addr_a)
                rd_data_a_reg <= wr_data;
            else if (written_reg[rd_addr_a])
                rd_data_a_reg <= mem[rd_addr_a];
            else
                rd_data_a_reg <= 8'd0;

            if (wr_en && wr_addr == rd_addr_b)
                rd_data_b_reg <= wr_data;
            else if (written_reg[rd_addr_b])
                rd_data_b_reg <= mem[rd_addr_b];
            else
                rd_data_b_reg <= 8'd0;
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// File: design/tbm_exec.sv
// execute stage: operand select, alu, jump compare, writeback decision
// depends on tbm_pkg
module tbm_exec (
    input  tbm_pkg::instr_t    instr,
    input  logic [7:0]         reg_a,
    input  logic [7:0]         reg_b,
    input  logic [7:0]         instr_index,
    output tbm_pkg::exec_res_t res
);
    import tbm_pkg::*;

    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [4:0] code;
    logic [7:0] alu;
    logic       take;
    logic       bad;

    function automatic logic [7:0] pick(input logic imm, input logic [7:0] sel,
                                        input logic [7:0] port, input logic [7:0] rdat);
        logic [7:0] v;
        if (imm)
            v = sel;
        else if (sel == PORT_SELECT_B)
            v = port;
        else if (sel < REG_COUNT_B)
            v = rdat;
        else
            v = 8'd0;
        return v;
    endfunction

    assign op_a = pick(instr.opcode[IMM_FIRST_BIT], instr.first_sel,
                       instr.port_in_first, reg_a);
    assign op_b = pick(instr.opcode[IMM_SECOND_BIT], instr.second_sel,
                       instr.port_in_second, reg_b);
    assign code = instr.opcode[4:0];

    always_comb
    begin
        alu  = 8'd0;
        take = 1'b0;
        bad  = 1'b0;
        if (instr.opcode[COND_BIT])
        begin
            unique case (code)
                CMP_EQ:  take = (op_a == op_b);
                CMP_NE:  take = (op_a != op_b);
                CMP_LT:  take = (op_a < op_b);
                CMP_LE:  take = (op_a <= op_b);
                CMP_GT:  take = (op_a > op_b);
                CMP_GE:  take = (op_a >= op_b);
                default: bad  = 1'b1;
            endcase
        end
        else
        begin
            unique case (code)
                OP_ADD:  alu = op_a + op_b;
                OP_SUB:  alu = op_a - op_b;
                OP_AND:  alu = op_a & op_b;
                OP_OR:   alu = op_a | op_b;
                OP_NOT:  alu = ~op_a;
                OP_XOR:  alu = op_a ^ op_b;
                default: bad = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        res                = '0;
        res.fault          = bad;
        res.wr_addr        = instr.target[REG_AW-1:0];
        res.wr_data        = alu;
        if (bad)
            res.next_index = instr_index;
        else if (instr.opcode[COND_BIT] && take)
            res.next_index = instr.target;
        else
            res.next_index = instr_index + 8'd1;

        // register destination wins over the output port
        if (!bad && !instr.opcode[COND_BIT])
        begin
            if (instr.target < REG_COUNT_B)
                res.wr_en = 1'b1;
            else if (instr.target == PORT_SELECT_B)
            begin
                res.port_out_valid = 1'b1;
                res.port_out_value = alu;
            end
        end
    end

endmodule

// File: design/tiny_byte_machine_execute.sv
// top level of the byte machine execute block
// depends on tbm_pkg, tbm_regfile, tbm_exec and assert_macros.svh
//
// Executes one instruction per clock cycle, back to back, as long as the
// result side keeps taking results. Each transaction passes two stages: at
// acceptance the register file memory is read at both operand selectors, and
// once the result register is free the execute stage forms the operands, runs
// the alu or the jump compare, writes the register file and loads the result
// register. A register written by one instruction is seen by the next through
// write-through on the memory read port. The register file resets to zero
// through per-entry written flags, with no clearing pass.
`include "assert_macros.svh"

module tiny_byte_machine_execute (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] instr_opcode,
    input  logic [7:0] first_sel,
    input  logic [7:0] second_sel,
    input  logic [7:0] target,
    input  logic [7:0] port_in_first,
    input  logic [7:0] port_in_second,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] next_index,
    output logic       port_out_valid,
    output logic [7:0] port_out_value,
    output logic       fault
);
    import tbm_pkg::*;

    instr_t            s1_instr_reg;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        instr_index_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        next_index_reg;
    logic              port_out_valid_reg;
    logic [7:0]        port_out_value_reg;
    logic              fault_reg;

    logic              accept;
    logic              s1_adv;
    logic [REG_AW-1:0] rd_addr_a;
    logic [REG_AW-1:0] rd_addr_b;
    logic [7:0]        reg_a;
    logic [7:0]        reg_b;
    exec_res_t         res;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    // out-of-range selectors read entry zero, the data is not used then
    assign rd_addr_a = (first_sel < REG_COUNT_B) ? first_sel[REG_AW-1:0] : '0;
    assign rd_addr_b = (second_sel < REG_COUNT_B) ? second_sel[REG_AW-1:0] : '0;

    tbm_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .wr_en     (s1_adv && res.wr_en),
        .wr_addr   (res.wr_addr),
        .wr_data   (res.wr_data),
        .rd_data_a (reg_a),
        .rd_data_b (reg_b)
    );

    tbm_exec u_exec (
        .instr       (s1_instr_reg),
        .reg_a       (reg_a),
        .reg_b       (reg_b),
        .instr_index (instr_index_reg),
        .res         (res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            instr_index_reg <= 8'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                instr_index_reg <= res.next_index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg.opcode         <= instr_opcode;
            s1_instr_reg.first_sel      <= first_sel;
            s1_instr_reg.second_sel     <= second_sel;
            s1_instr_reg.target         <= target;
            s1_instr_reg.port_in_first  <= port_in_first;
            s1_instr_reg.port_in_second <= port_in_second;
        end
        if (s1_adv)
        begin
            next_index_reg     <= res.next_index;
            port_out_valid_reg <= res.port_out_valid;
            port_out_value_reg <= res.port_out_value;
            fault_reg          <= res.fault;
        end
    end

    assign out_valid      = out_valid_reg;
    assign next_index     = next_index_reg;
    assign port_out_valid = port_out_valid_reg;
    assign port_out_value = port_out_value_reg;
    assign fault          = fault_reg;

    `ASSERT_CLK(a_fault_no_port, (out_valid_reg && fault_reg) |-> !port_out_valid_reg,
        "faulting instruction drove the output port")
    `ASSERT_CLK(a_index_hold, (s1_valid_reg && !s1_adv) |=> $stable(instr_index_reg),
        "instruction index moved while execute stage stalled")
    `ASSERT_CLK(a_fault_index, (s1_adv && res.fault) |=> $stable(instr_index_reg),
        "faulting instruction changed the instruction index")
    `ASSERT_NEVER(a_ready_stall, !in_ready && !(s1_valid_reg && out_valid_reg && !out_ready),
        "input held off without a downstream stall")

endmodule

// File: sim/tiny_byte_machine_execute_test.sv
// self-checking testbench for tiny_byte_machine_execute
// depends on tbm_pkg and the design files; its model predicts all but known rows
`timescale 1ns / 100ps

module tiny_byte_machine_execute_test;
    import tbm_pkg::*;

    localparam logic [7:0] IMM1 = 8'h80;
    localparam logic [7:0] IMM2 = 8'h40;
    localparam logic [7:0] COND = 8'h20;
    localparam logic [7:0] PORT = PORT_SELECT_B;

    // operation codes that the block does not know
    localparam logic [4:0] CODE_BAD_LO = 5'd6;
    localparam logic [4:0] CODE_BAD_HI = 5'd31;

    localparam int RANDOM_ITEMS   = 600;
    localparam int CALM_FROM      = 520;
    localparam int HOLD_AFTER     = 40;
    localparam int HOLD_CYCLES    = 90;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 23;

    typedef struct packed {
        logic [7:0] next_index;
        logic       port_out_valid;
        logic [7:0] port_out_value;
        logic       fault;
    } outcome_t;

    typedef struct packed {
        instr_t   item;
        logic     known;
        outcome_t want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] instr_opcode;
    logic [7:0] first_sel;
    logic [7:0] second_sel;
    logic [7:0] target;
    logic [7:0] port_in_first;
    logic [7:0] port_in_second;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] next_index;
    logic       port_out_valid;
    logic [7:0] port_out_value;
    logic       fault;

    logic [7:0] model_regs [REG_COUNT];
    logic [7:0] model_pc;
    outcome_t   pending_outcomes [$];
    int         fail_count;
    int         results_seen;
    int         idle_cycles;
    bit         calm;

    // rows marked known carry an expectation read straight off the spec
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{IMM1 | IMM2 | CODE_BAD_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{8'h00, 1'b0, 8'h00, 1'b1}},
        '{'{IMM1 | IMM2 | OP_ADD, 8'hFF, 8'h01, PORT, 8'h00, 8'h00}, 1'b1,
          '{8'h01, 1'b1, 8'h00, 1'b0}},
        '{'{IMM1 | IMM2 | OP_SUB, 8'h00, 8'h01, PORT, 8'h00, 8'h00}, 1'b1,
          '{8'h02, 1'b1, 8'hFF, 1'b0}},
        '{'{IMM1 | IMM2 | OP_AND, 8'hF0, 8'h3C, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h03, 1'b0, 8'h00, 1'b0}},
        '{'{IMM2 | OP_OR, 8'h00, 8'h0F, PORT, 8'h00, 8'h00}, 1'b0, '0},
        '{'{8'(OP_NOT), PORT, 8'h00, PORT, 8'hAA, 8'hFF}, 1'b0, '0},
        '{'{8'(OP_XOR), PORT, PORT, 8'h05, 8'hFF, 8'h0F}, 1'b0, '0},
        '{'{8'(OP_ADD), 8'd200, 8'h05, PORT, 8'h00, 8'h00}, 1'b0, '0},
        '{'{8'(OP_ADD), 8'h06, 8'h00, PORT, 8'h00, 8'h00}, 1'b0, '0},
        '{'{IMM1 | IMM2 | OP_ADD, 8'h01, 8'h02, 8'h06, 8'h00, 8'h00}, 1'b1,
          '{8'h09, 1'b0, 8'h00, 1'b0}},
        '{'{IMM1 | IMM2 | OP_XOR, 8'h01, 8'h02, 8'hFF, 8'h00, 8'h00}, 1'b1,
          '{8'h0A, 1'b0, 8'h00, 1'b0}},
        '{'{IMM1 | IMM2 | CODE_BAD_LO, 8'h01, 8'h02, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'h0A, 1'b0, 8'h00, 1'b1}},
        '{'{COND | CMP_EQ, 8'h00, 8'h05, 8'h80, 8'h00, 8'h00}, 1'b0, '0},
        '{'{COND | CMP_NE, 8'h00, 8'h05, 8'h40, 8'h00, 8'h00}, 1'b0, '0},
        '{'{COND | CMP_LT, PORT, PORT, 8'h20, 8'h00, 8'hFF}, 1'b0, '0},
        '{'{COND | CMP_LE, PORT, PORT, 8'h10, 8'hFF, 8'hFF}, 1'b0, '0},
        '{'{COND | CMP_GT, PORT, 8'h00, 8'h11, 8'h31, 8'h00}, 1'b0, '0},
        '{'{IMM1 | IMM2 | COND | CMP_GE, 8'h03, 8'h04, 8'h99, 8'h00, 8'h00}, 1'b0, '0},
        '{'{IMM1 | IMM2 | COND | CMP_EQ, 8'h5A, 8'h5A, 8'hFF, 8'h00, 8'h00}, 1'b1,
          '{8'hFF, 1'b0, 8'h00, 1'b0}},
        '{'{COND | CODE_BAD_LO, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1,
          '{8'hFF, 1'b0, 8'h00, 1'b1}},
        '{'{IMM1 | IMM2 | COND | CODE_BAD_HI, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1,
          '{8'hFF, 1'b0, 8'h00, 1'b1}},
        '{'{IMM1 | IMM2 | OP_OR, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00}, 1'b1,
          '{8'h00, 1'b0, 8'h00, 1'b0}},
        '{'{IMM1 | OP_SUB, 8'h00, PORT, PORT, 8'h00, 8'h01}, 1'b0, '0}
    };

    tiny_byte_machine_execute dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .instr_opcode   (instr_opcode),
        .first_sel      (first_sel),
        .second_sel     (second_sel),
        .target         (target),
        .port_in_first  (port_in_first),
        .port_in_second (port_in_second),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .next_index     (next_index),
        .port_out_valid (port_out_valid),
        .port_out_value (port_out_value),
        .fault          (fault)
    );

    always #1 clk = ~clk;

    function automatic logic [7:0] operand_value(input logic imm, input logic [7:0] sel,
                                                 input logic [7:0] port_byte);
        if (imm)
            return sel;
        if (sel == PORT_SELECT_B)
            return port_byte;
        if (sel < REG_COUNT_B)
            return model_regs[sel[REG_AW-1:0]];
        return 8'h00;
    endfunction

    // runs one instruction against the model state and returns its outcome
    function automatic outcome_t execute_instr(input instr_t it);
        outcome_t   res;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] alu;
        logic [4:0] code;
        logic       take;
        a    = operand_value(it.opcode[IMM_FIRST_BIT], it.first_sel, it.port_in_first);
        b    = operand_value(it.opcode[IMM_SECOND_BIT], it.second_sel, it.port_in_second);
        code = it.opcode[4:0];
        res  = '0;
        res.next_index = model_pc + 8'd1;
        take = 1'b0;
        alu  = 8'h00;
        if (it.opcode[COND_BIT])
        begin
            case (code)
                CMP_EQ:  take = (a == b);
                CMP_NE:  take = (a != b);
                CMP_LT:  take = (a < b);
                CMP_LE:  take = (a <= b);
                CMP_GT:  take = (a > b);
                CMP_GE:  take = (a >= b);
                default: res.fault = 1'b1;
            endcase
            if (res.fault)
                res.next_index = model_pc;
            else if (take)
                res.next_index = it.target;
        end
        else
        begin
            case (code)
                OP_ADD:  alu = a + b;
                OP_SUB:  alu = a - b;
                OP_AND:  alu = a & b;
                OP_OR:   alu = a | b;
                OP_NOT:  alu = ~a;
                OP_XOR:  alu = a ^ b;
                default: res.fault = 1'b1;
            endcase
            if (res.fault)
                res.next_index = model_pc;
            else if (it.target < REG_COUNT_B)
                model_regs[it.target[REG_AW-1:0]] = alu;
            else if (it.target == PORT_SELECT_B)
            begin
                res.port_out_valid = 1'b1;
                res.port_out_value = alu;
            end
        end
        model_pc = res.next_index;
        return res;
    endfunction

    // selectors lean toward registers and the port so that operands carry data
    function automatic logic [7:0] random_selector();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return 8'($urandom_range(0, REG_COUNT - 1));
        if (pick < 7)
            return PORT_SELECT_B;
        if (pick == 7)
            return REG_COUNT_B;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic instr_t random_instr();
        instr_t it;
        it.opcode[7:5] = 3'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0)
            it.opcode[4:0] = 5'($urandom_range(CODE_BAD_LO, CODE_BAD_HI));
        else
            it.opcode[4:0] = 5'($urandom_range(0, 5));
        it.first_sel      = it.opcode[IMM_FIRST_BIT] ? 8'($urandom_range(0, 255))
                                                     : random_selector();
        it.second_sel     = it.opcode[IMM_SECOND_BIT] ? 8'($urandom_range(0, 255))
                                                      : random_selector();
        it.target         = it.opcode[COND_BIT] ? 8'($urandom_range(0, 255))
                                                : random_selector();
        it.port_in_first  = 8'($urandom_range(0, 255));
        it.port_in_second = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        fail_count++;
    endtask

    // offers one instruction and returns after the edge that accepts it
    task automatic send_instr(input instr_t it, input logic known, input outcome_t want);
        outcome_t predicted;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        instr_opcode   <= it.opcode;
        first_sel      <= it.first_sel;
        second_sel     <= it.second_sel;
        target         <= it.target;
        port_in_first  <= it.port_in_first;
        port_in_second <= it.port_in_second;
        do @(posedge clk); while (!in_ready);
        predicted = execute_instr(it);
        if (known)
            predicted = want;
        pending_outcomes.insert(pending_outcomes.size(), predicted);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        instr_opcode   = '0;
        first_sel      = '0;
        second_sel     = '0;
        target         = '0;
        port_in_first  = '0;
        port_in_second = '0;
        fail_count     = 0;
        results_seen   = 0;
        calm           = 1'b0;
        model_pc       = '0;
        for (int i = 0; i < REG_COUNT; i++)
            model_regs[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_instr(dir_rows[i].item, dir_rows[i].known, dir_rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == CALM_FROM)
                calm = 1'b1;
            send_instr(random_instr(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // result side: random stalls, one long hold-off to back the block up
    initial
    begin
        bit squeezed;
        squeezed = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!squeezed && results_seen >= HOLD_AFTER)
            begin
                squeezed = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected transaction next_index", 8'h00, next_index);
            else
            begin
                want = pending_outcomes.pop_front();
                if (next_index !== want.next_index)
                    report_mismatch("next_index", want.next_index, next_index);
                if (port_out_valid !== want.port_out_valid)
                    report_mismatch("port_out_valid", 8'(want.port_out_valid),
                                    8'(port_out_valid));
                if (port_out_value !== want.port_out_value)
                    report_mismatch("port_out_value", want.port_out_value, port_out_value);
                if (fault !== want.fault)
                    report_mismatch("fault", 8'(want.fault), 8'(fault));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired at %0t", $realtime);
            $display("Verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
